/* rtl/ufbd_pkg.sv */
// Shared types, codes and constants for the UART fractional baud divisor search.
package ufbd_pkg;

  typedef struct packed {
    logic [31:0] clock_rate;
    logic [23:0] baud_rate;
  } ufbd_in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] divisor;
    logic [3:0]  mul_value;
    logic [3:0]  div_add_value;
    logic [7:0]  error_percent;
  } ufbd_out_item_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_DIV   = 2'd1;
  localparam logic [1:0] STATUS_ERR_HIGH = 2'd2;

  localparam int          FRAC_SHIFT     = 28;
  localparam logic [31:0] HALF_FRAC      = 32'h8000_0000;
  localparam logic [32:0] DIV_MAX        = 33'd65536;
  localparam logic [38:0] PCT_SCALE      = 39'd100;
  localparam logic [7:0]  ERR_SAT        = 8'd255;
  localparam logic [6:0]  MAX_ERR_RESET  = 7'd3;

  // Shared divider geometry
  localparam int DVD_W     = 64;
  localparam int DVS_W     = 29;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    OP_PAIR,
    OP_ACT,
    OP_PCT
  } ufbd_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_PAIR_GO,
    ST_PAIR_WAIT,
    ST_SEARCH_END,
    ST_ACT_GO,
    ST_ACT_WAIT,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_PUT_RESULT,
    ST_PUT_NONE
  } ufbd_state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    ufbd_op_t op;
    logic     pair_eval;
    logic     diff_load;
    logic     put_result;
    logic     put_none;
  } ufbd_cmd_t;

  typedef struct packed {
    logic baud_zero;
    logic div_done;
    logic exact_hit;
    logic last_pair;
    logic found;
    logic out_free;
  } ufbd_sts_t;

endpackage

/* rtl/ufbd_divider.sv */
// Iterative restoring divider, one quotient bit per cycle, shared by all divisions.
module ufbd_divider import ufbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0]     qd_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  assign trial     = {rem_r, qd_r[DVD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign rem_nxt   = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      qd_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      qd_r  <= {qd_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = qd_r;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r) else $error("divider did not begin after start");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still stepping");
`endif

endmodule

/* rtl/ufbd_ctrl.sv */
// Sequencer for the candidate search, baud recompute and result hand-off.
module ufbd_ctrl import ufbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ufbd_sts_t sts,
  output ufbd_cmd_t cmd
);

  ufbd_state_t state_r;
  ufbd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = sts.baud_zero ? ST_PUT_NONE : ST_PAIR_GO;
      end
      ST_PAIR_GO: begin
        state_nxt = ST_PAIR_WAIT;
      end
      ST_PAIR_WAIT: begin
        if (sts.div_done) begin
          priority if (sts.exact_hit) state_nxt = ST_ACT_GO;
          else if (sts.last_pair)     state_nxt = ST_SEARCH_END;
          else                        state_nxt = ST_PAIR_GO;
        end
      end
      ST_SEARCH_END: begin
        state_nxt = sts.found ? ST_ACT_GO : ST_PUT_NONE;
      end
      ST_ACT_GO: begin
        state_nxt = ST_ACT_WAIT;
      end
      ST_ACT_WAIT: begin
        if (sts.div_done) state_nxt = ST_PCT_GO;
      end
      ST_PCT_GO: begin
        state_nxt = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (sts.div_done) state_nxt = ST_PUT_RESULT;
      end
      ST_PUT_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_PUT_NONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = OP_PAIR;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PAIR_GO: begin
        cmd.div_start = 1'b1;
        cmd.op        = OP_PAIR;
      end
      ST_PAIR_WAIT: begin
        cmd.pair_eval = sts.div_done;
      end
      ST_ACT_GO: begin
        cmd.div_start = 1'b1;
        cmd.op        = OP_ACT;
      end
      ST_ACT_WAIT: begin
        cmd.diff_load = sts.div_done;
      end
      ST_PCT_GO: begin
        cmd.div_start = 1'b1;
        cmd.op        = OP_PCT;
      end
      ST_PUT_RESULT: begin
        cmd.put_result = sts.out_free;
      end
      ST_PUT_NONE: begin
        cmd.put_none = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/ufbd_datapath.sv */
// Operand formation, rounding and best-pair tracking, error percent and result register.
module ufbd_datapath import ufbd_pkg::*; #(
  parameter int unsigned MAX_MULTIPLIER = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ufbd_in_item_t    in_data,
  input  logic             cfg_valid,
  input  logic [6:0]       cfg_data,
  input  ufbd_cmd_t        cmd,
  output ufbd_sts_t        sts,
  output logic [DVD_W-1:0] div_dividend,
  output logic [DVS_W-1:0] div_divisor,
  input  logic             div_done,
  input  logic [DVD_W-1:0] div_quotient,
  output logic             out_valid,
  input  logic             out_stall,
  output ufbd_out_item_t   out_data
);

  logic [6:0]     max_err_r;
  logic [31:0]    clk_rate_r;
  logic [23:0]    baud_r;
  logic [3:0]     m_r;
  logic [3:0]     d_r;
  logic [31:0]    best_err_r;
  logic [16:0]    best_div_r;
  logic [3:0]     best_m_r;
  logic [3:0]     best_d_r;
  logic [31:0]    diff_r;
  ufbd_out_item_t out_data_r;
  logic           out_valid_r;

  logic [4:0]     pair_sum;
  logic [4:0]     best_sum;
  logic [35:0]    pair_num;
  logic [31:0]    act_num;
  logic [21:0]    act_den;
  logic [38:0]    pct_num;

  logic [31:0]    frac;
  logic           round_up;
  logic [31:0]    frac_adj;
  logic [32:0]    whole_adj;
  logic           in_range;
  logic           better;
  logic           last_d;

  logic [31:0]    actual;
  logic [31:0]    baud_ext;
  logic           err_below;
  logic [7:0]     err_sat;
  logic           out_free;
  ufbd_out_item_t res_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_err_r <= MAX_ERR_RESET;
    end else if (cfg_valid) begin
      max_err_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clk_rate_r <= in_data.clock_rate;
      baud_r     <= in_data.baud_rate;
    end
    if (cmd.diff_load) begin
      diff_r <= (baud_ext > actual) ? (baud_ext - actual) : (actual - baud_ext);
    end
  end

  // Operands for the shared divider
  assign pair_sum = 5'(m_r) + 5'(d_r);
  assign best_sum = 5'(best_m_r) + 5'(best_d_r);
  assign pair_num = 36'(clk_rate_r) * 36'(m_r);
  assign act_num  = 32'(clk_rate_r[31:4]) * 32'(best_m_r);
  assign act_den  = 22'(best_div_r) * 22'(best_sum);
  assign pct_num  = 39'(diff_r) * PCT_SCALE;

  always_comb begin
    unique case (cmd.op)
      OP_PAIR: begin
        div_dividend = {pair_num, {FRAC_SHIFT{1'b0}}};
        div_divisor  = DVS_W'(baud_r) * DVS_W'(pair_sum);
      end
      OP_ACT: begin
        div_dividend = DVD_W'(act_num);
        div_divisor  = DVS_W'(act_den);
      end
      OP_PCT: begin
        div_dividend = DVD_W'(pct_num);
        div_divisor  = DVS_W'(baud_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DVS_W'(baud_r);
      end
    endcase
  end

  // Round to nearest, exact half rounds down
  assign frac      = div_quotient[31:0];
  assign round_up  = (frac > HALF_FRAC);
  assign frac_adj  = round_up ? (32'd0 - frac) : frac;
  assign whole_adj = {1'b0, div_quotient[63:32]} + 33'(round_up);
  assign in_range  = (whole_adj != 33'd0) && (whole_adj <= DIV_MAX);
  assign better    = in_range && (frac_adj < best_err_r);
  assign last_d    = (d_r == (m_r - 4'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r        <= 4'd1;
      d_r        <= 4'd0;
      best_err_r <= '1;
      best_div_r <= '0;
      best_m_r   <= '0;
      best_d_r   <= '0;
    end else if (cmd.load) begin
      m_r        <= 4'd1;
      d_r        <= 4'd0;
      best_err_r <= '1;
      best_div_r <= '0;
      best_m_r   <= '0;
      best_d_r   <= '0;
    end else if (cmd.pair_eval) begin
      if (better) begin
        best_err_r <= frac_adj;
        best_div_r <= whole_adj[16:0];
        best_m_r   <= m_r;
        best_d_r   <= d_r;
      end
      if (last_d) begin
        m_r <= m_r + 4'd1;
        d_r <= 4'd0;
      end else begin
        d_r <= d_r + 4'd1;
      end
    end
  end

  // Result assembly from the percent quotient
  assign actual    = div_quotient[31:0];
  assign baud_ext  = 32'(baud_r);
  assign err_below = (div_quotient[63:7] == '0) && (div_quotient[6:0] < max_err_r);
  assign err_sat   = (div_quotient[63:8] != '0) ? ERR_SAT : div_quotient[7:0];

  always_comb begin
    res_item               = '0;
    res_item.status        = STATUS_NO_DIV;
    if (cmd.put_result) begin
      res_item.status        = err_below ? STATUS_OK : STATUS_ERR_HIGH;
      res_item.divisor       = best_div_r;
      res_item.mul_value     = best_m_r;
      res_item.div_add_value = best_d_r;
      res_item.error_percent = err_sat;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.put_result || cmd.put_none) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_result || cmd.put_none) begin
      out_data_r <= res_item;
    end
  end

  assign sts.baud_zero = (baud_r == 24'd0);
  assign sts.div_done  = div_done;
  assign sts.exact_hit = better && (frac_adj == 32'd0);
  assign sts.last_pair = last_d && (m_r == 4'(MAX_MULTIPLIER));
  assign sts.found     = (best_div_r != 17'd0);
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_best_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (best_div_r != 17'd0) |-> (best_d_r < best_m_r))
    else $error("kept add value not below multiplier");
  a_best_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (best_div_r != 17'd0) |-> (best_div_r <= 17'd65536) && (best_m_r != 4'd0))
    else $error("kept divisor out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_result || cmd.put_none) |-> out_free)
    else $error("result written over an untaken transaction");
`endif

endmodule

/* rtl/uart_fractional_baud_divisor_search_unit.sv */
// Top level of the UART fractional baud divisor search unit.
// One transaction at a time: a clock rate and baud rate go in, one result comes
// out. Every candidate multiplier/add pair takes one pass through the shared
// 64-step restoring divider (one quotient bit per cycle); with MAX_MULTIPLIER
// m the search covers up to m*(m+1)/2 pairs (120 at the default), stopping at
// the first exact fit. The recomputed baud and the error percent take two more
// divider passes; a zero baud skips the search and gives a no-divisor result.
// A finished result waits in the output register while the next transaction
// is accepted. The threshold register may be written at any time the unit is
// idle; cfg_ready stays high.
module uart_fractional_baud_divisor_search_unit import ufbd_pkg::*; #(
  parameter int unsigned MAX_MULTIPLIER = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ufbd_in_item_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ufbd_out_item_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [6:0]     cfg_data
);

  ufbd_cmd_t        cmd;
  ufbd_sts_t        sts;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quotient;

  assign cfg_ready = 1'b1;

  ufbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ufbd_datapath #(
    .MAX_MULTIPLIER (MAX_MULTIPLIER)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  ufbd_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule
